// ===== hdl/vmt_pkg.sv =====
// Shared types, widths and a reset helper function for the vertex matrix transform.
package vmt_pkg;

  localparam int DIM           = 4;
  localparam int NUM_REGS      = (DIM * DIM) / 2;
  localparam int COEF_W        = 32;
  localparam int REG_W         = 2 * COEF_W;
  localparam int IDX_W         = $clog2(NUM_REGS);
  localparam int ADDR_W        = IDX_W + 3;
  localparam int PROD_W        = 2 * COEF_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;

  // Clamp limits of a 32-bit signed result, at the width of the full sum.
  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] OUT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] OUT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef logic [DIM-1:0][COEF_W-1:0] vec_t;
  typedef logic [DIM-1:0][SUM_W-1:0]  sum_vec_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_pair;
    logic ld_sum;
    logic ld_out;
  } pipe_ctl_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
  } apb_req_t;

  // Reset value of one matrix register: identity matrix with 1.0 = 2^frac.
  function automatic logic [REG_W-1:0] mat_reset(input int idx, input int frac);
    logic [REG_W-1:0] one;
    logic [REG_W-1:0] val;
    int               e;
    one = REG_W'(1) << frac;
    val = '0;
    for (int r = 0; r < DIM; r++) begin
      e = r * (DIM + 1);
      if ((e >> 1) == idx) begin
        if (e[0]) begin
          val = val | (one << COEF_W);
        end else begin
          val = val | one;
        end
      end
    end
    return val;
  endfunction

endpackage

// ===== hdl/vmt_vert_if.sv =====
// Vertex input channel: valid/ready handshake with x, y, z, w payload.
interface vmt_vert_if;
  logic                                valid;
  logic                                ready;
  logic signed [vmt_pkg::COEF_W-1:0]   vert_x;
  logic signed [vmt_pkg::COEF_W-1:0]   vert_y;
  logic signed [vmt_pkg::COEF_W-1:0]   vert_z;
  logic signed [vmt_pkg::COEF_W-1:0]   vert_w;

  modport source (output valid, output vert_x, output vert_y, output vert_z, output vert_w,
                  input ready);
  modport sink   (input valid, input vert_x, input vert_y, input vert_z, input vert_w,
                  output ready);
endinterface

// ===== hdl/vmt_res_if.sv =====
// Result channel: valid/ready handshake with transformed x, y, z, w payload.
interface vmt_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [vmt_pkg::COEF_W-1:0]   out_x;
  logic signed [vmt_pkg::COEF_W-1:0]   out_y;
  logic signed [vmt_pkg::COEF_W-1:0]   out_z;
  logic signed [vmt_pkg::COEF_W-1:0]   out_w;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  output ready);
endinterface

// ===== hdl/vmt_regs.sv =====
// Matrix coefficient registers with APB-style write/read access.
module vmt_regs #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vmt_pkg::apb_req_t          req,
  output logic [vmt_pkg::REG_W-1:0]  prdata,
  output vmt_pkg::vec_t              coef [vmt_pkg::DIM]
);

  logic [vmt_pkg::REG_W-1:0] mat [vmt_pkg::NUM_REGS];
  logic [vmt_pkg::IDX_W-1:0] reg_idx;
  logic                      wr_en;

  assign reg_idx = req.paddr[vmt_pkg::ADDR_W-1:3];
  assign wr_en   = req.psel && req.penable && req.pwrite;
  assign prdata  = mat[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < vmt_pkg::NUM_REGS; r++) begin
        mat[r] <= vmt_pkg::mat_reset(r, FRAC_BITS);
      end
    end else if (wr_en) begin
      mat[reg_idx] <= req.pwdata;
    end
  end

  // Even column in the low half, odd column in the high half.
  for (genvar row = 0; row < vmt_pkg::DIM; row++) begin : g_row
    for (genvar col = 0; col < vmt_pkg::DIM; col++) begin : g_col
      localparam int RIDX = (row * vmt_pkg::DIM + col) / 2;
      if ((col % 2) == 1) begin : g_hi
        assign coef[row][col] = mat[RIDX][vmt_pkg::REG_W-1:vmt_pkg::COEF_W];
      end else begin : g_lo
        assign coef[row][col] = mat[RIDX][vmt_pkg::COEF_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/vmt_lane.sv =====
// One matrix row lane: four multipliers, then a two-level registered add tree.
module vmt_lane (
  input  logic                              clk,
  input  vmt_pkg::pipe_ctl_t                ctl,
  input  vmt_pkg::vec_t                     vert,
  input  vmt_pkg::vec_t                     coef,
  output logic signed [vmt_pkg::SUM_W-1:0]  sum
);

  logic signed [vmt_pkg::PROD_W-1:0] prod [vmt_pkg::DIM];
  logic signed [vmt_pkg::PAIR_W-1:0] pair [vmt_pkg::DIM/2];

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      for (int j = 0; j < vmt_pkg::DIM; j++) begin
        prod[j] <= $signed(coef[j]) * $signed(vert[j]);
      end
    end
    if (ctl.ld_pair) begin
      for (int k = 0; k < vmt_pkg::DIM / 2; k++) begin
        pair[k] <= vmt_pkg::PAIR_W'(prod[2*k]) + vmt_pkg::PAIR_W'(prod[2*k+1]);
      end
    end
    if (ctl.ld_sum) begin
      sum <= vmt_pkg::SUM_W'(pair[0]) + vmt_pkg::SUM_W'(pair[1]);
    end
  end

endmodule

// ===== hdl/vmt_merge.sv =====
// Output stage: scales each lane sum, clamps to 32 bits and registers the vertex.
module vmt_merge #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              ld,
  input  vmt_pkg::sum_vec_t sums,
  output vmt_pkg::vec_t     res_q
);

  logic signed [vmt_pkg::SUM_W-1:0] shifted [vmt_pkg::DIM];
  vmt_pkg::vec_t                    sat_val;

  // Arithmetic shift floors negative sums, matching the exact fixed-point result.
  always_comb begin
    for (int i = 0; i < vmt_pkg::DIM; i++) begin
      shifted[i] = $signed(sums[i]) >>> FRAC_BITS;
      if (shifted[i] > vmt_pkg::SAT_MAX) begin
        sat_val[i] = vmt_pkg::OUT_MAX;
      end else if (shifted[i] < vmt_pkg::SAT_MIN) begin
        sat_val[i] = vmt_pkg::OUT_MIN;
      end else begin
        sat_val[i] = shifted[i][vmt_pkg::COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_q <= sat_val;
    end
  end

endmodule

// ===== hdl/vertex_matrix_transform.sv =====
// Pipeline: products are registered at the input transfer edge, then the pair add, the
// final add and the clamp/output register follow, after which the result is valid.
// Throughput: one vertex per cycle while the output accepts, set by the four row lanes
// of four 32x32 multipliers each; stages with bubbles keep filling while the output is
// stalled. Synchronous reset empties the pipeline and loads the identity matrix into
// the coefficient registers.
module vertex_matrix_transform #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  vmt_vert_if.sink                    vert,
  vmt_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vmt_pkg::ADDR_W-1:0]  paddr,
  input  logic [vmt_pkg::REG_W-1:0]   pwdata,
  output logic [vmt_pkg::REG_W-1:0]   prdata,
  output logic                        pready
);

  vmt_pkg::apb_req_t  apb_req;
  vmt_pkg::pipe_ctl_t ctl;
  vmt_pkg::vec_t      coef [vmt_pkg::DIM];
  vmt_pkg::vec_t      vin;
  vmt_pkg::sum_vec_t  lane_sum;
  vmt_pkg::vec_t      res_q;

  logic mul_valid;
  logic pair_valid;
  logic sum_valid;
  logic out_valid;

  assign apb_req.psel    = psel;
  assign apb_req.penable = penable;
  assign apb_req.pwrite  = pwrite;
  assign apb_req.paddr   = paddr;
  assign apb_req.pwdata  = pwdata;
  assign pready          = 1'b1;

  vmt_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk    (clk),
    .rst    (rst),
    .req    (apb_req),
    .prdata (prdata),
    .coef   (coef)
  );

  assign vin[0] = vert.vert_x;
  assign vin[1] = vert.vert_y;
  assign vin[2] = vert.vert_z;
  assign vin[3] = vert.vert_w;

  // A stage loads when it is empty or its contents move on this cycle.
  assign ctl.ld_out  = !out_valid  || res.ready;
  assign ctl.ld_sum  = !sum_valid  || ctl.ld_out;
  assign ctl.ld_pair = !pair_valid || ctl.ld_sum;
  assign ctl.ld_mul  = !mul_valid  || ctl.ld_pair;

  assign vert.ready = ctl.ld_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid  <= 1'b0;
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.ld_mul)  mul_valid  <= vert.valid;
      if (ctl.ld_pair) pair_valid <= mul_valid;
      if (ctl.ld_sum)  sum_valid  <= pair_valid;
      if (ctl.ld_out)  out_valid  <= sum_valid;
    end
  end

  for (genvar i = 0; i < vmt_pkg::DIM; i++) begin : g_lane
    vmt_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .vert (vin),
      .coef (coef[i]),
      .sum  (lane_sum[i])
    );
  end

  vmt_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk   (clk),
    .ld    (ctl.ld_out),
    .sums  (lane_sum),
    .res_q (res_q)
  );

  assign res.valid = out_valid;
  assign res.out_x = res_q[0];
  assign res.out_y = res_q[1];
  assign res.out_z = res_q[2];
  assign res.out_w = res_q[3];

  // An empty output register must never back-pressure the input.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> vert.ready)
    else $error("input stalled with empty output stage");

  // Every stage full and the output stalled: no new transfer may be taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (mul_valid && pair_valid && sum_valid && out_valid && !res.ready) |-> !vert.ready)
    else $error("input taken while pipeline is full and stalled");

  // Output drains to empty when nothing is behind it.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.ready && !sum_valid) |=> !out_valid)
    else $error("result repeated after transfer");

endmodule

// ===== sim/vmt_checker.sv =====
// Monitor and scoreboard for the vertex matrix transform: tracks the matrix, predicts results.
`timescale 1ns / 1ps

module vmt_checker #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  vmt_vert_if                         vert,
  vmt_res_if                          res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [vmt_pkg::ADDR_W-1:0]  paddr,
  input  logic [vmt_pkg::REG_W-1:0]   pwdata,
  output int                          mismatches,
  output int                          pending,
  output int                          results_checked,
  output int                          clamped
);
  import vmt_pkg::*;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  localparam string FIELD_NAME [DIM] = '{"out_x", "out_y", "out_z", "out_w"};

  matrix_t coefs;
  vec_t    expected_verts[$];
  vec_t    got;
  vec_t    want;
  int      n_clamp;

  function automatic matrix_t identity_matrix();
    matrix_t m;
    int      e;
    m = '0;
    for (int r = 0; r < DIM; r++) begin
      e = r * (DIM + 1);
      m[e / 2] = m[e / 2] | (REG_W'(1) << (FRAC_BITS + (e % 2) * COEF_W));
    end
    return m;
  endfunction

  // Exact 66-bit row sums, floor shift, then clamp to 32 bits.
  function automatic vec_t transform_vertex(input matrix_t m, input vec_t v,
                                            output int n_sat);
    logic signed [SUM_W-1:0]  acc;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] vc;
    logic signed [PROD_W-1:0] p;
    logic [REG_W-1:0]         word;
    vec_t                     o;
    n_sat = 0;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        word = m[(r * DIM + k) / 2];
        c = (k % 2 == 1) ? word[REG_W-1:COEF_W] : word[COEF_W-1:0];
        vc = v[k];
        p = c * vc;
        acc = acc + p;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_MAX) begin
        o[r] = OUT_MAX;
        n_sat++;
      end else if (acc < SAT_MIN) begin
        o[r] = OUT_MIN;
        n_sat++;
      end else begin
        o[r] = acc[COEF_W-1:0];
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coefs = identity_matrix();
      expected_verts.delete();
      mismatches = 0;
      results_checked = 0;
      clamped = 0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[ADDR_W-1:3] < NUM_REGS)) begin
        coefs[paddr[ADDR_W-1:3]] = pwdata;
      end
      if (vert.valid && vert.ready) begin
        expected_verts.push_back(transform_vertex(coefs,
          {vert.vert_w, vert.vert_z, vert.vert_y, vert.vert_x}, n_clamp));
        clamped += n_clamp;
      end
      if (res.valid && res.ready) begin
        got = {res.out_w, res.out_z, res.out_y, res.out_x};
        if (expected_verts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transfer, expected none, actual %h %h %h %h",
                   $time, got[0], got[1], got[2], got[3]);
        end else begin
          want = expected_verts.pop_front();
          results_checked++;
          for (int f = 0; f < DIM; f++) begin
            if (got[f] !== want[f]) begin
              mismatches++;
              $display("%0t: %s expected %h actual %h", $time, FIELD_NAME[f],
                       want[f], got[f]);
            end
          end
        end
      end
    end
    pending = expected_verts.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the vertex matrix transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import vmt_pkg::*;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  localparam int REG_STRIDE     = 8;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int HOLD_PHASE     = 2;
  localparam int PAUSE_PHASE    = 4;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  int mismatches;
  int pending;
  int results_checked;
  int clamped;
  int verts_sent;
  int settings_used;
  int quiet_cycles;
  int stall_left;
  bit bursts_on;
  bit hold_req;

  vec_t    limit_verts [4];
  vec_t    ident_verts [8];
  vec_t    round_verts [4];

  vmt_vert_if vi ();
  vmt_res_if  ri ();

  vertex_matrix_transform u_dut (
    .clk     (clk),
    .rst     (rst),
    .vert    (vi),
    .res     (ri),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vmt_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .vert            (vi),
    .res             (ri),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .clamped         (clamped)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic vec_t mk(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] w);
    return {w, z, y, x};
  endfunction

  // Mostly small values so the sums stay in range; extremes and full words mixed in.
  function automatic logic [31:0] rand_word();
    int s;
    s = 0;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3, 4, 5, 6: begin
        s = int'($urandom_range(0, 262144)) - 131072;
        return s;
      end
      7: return 32'h8000_0000;
      8: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 1) ? 32'hFFFF_0000 : 32'h0001_0000;
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    for (int i = 0; i < NUM_REGS; i++) begin
      m[i] = {rand_word(), rand_word()};
    end
    return m;
  endfunction

  task automatic write_reg(input int idx, input logic [REG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * REG_STRIDE);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic set_matrix(input matrix_t m);
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(i, m[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  task automatic send_vertex(input vec_t v);
    int gap;
    gap = (bursts_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      vi.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vi.valid  <= 1'b1;
    vi.vert_x <= v[0];
    vi.vert_y <= v[1];
    vi.vert_z <= v[2];
    vi.vert_w <= v[3];
    do @(posedge clk); while (!vi.ready);
    @(negedge clk);
    verts_sent++;
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic wait_drained();
    vi.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    ri.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        ri.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        ri.ready <= 1'b0;
        stall_left = LONG_HOLD - 1;
        hold_req = 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        ri.ready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        ri.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (vi.valid && vi.ready) || (ri.valid && ri.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    vi.valid  = 1'b0;
    vi.vert_x = '0;
    vi.vert_y = '0;
    vi.vert_z = '0;
    vi.vert_w = '0;
    bursts_on = 1'b1;
    hold_req  = 1'b0;
    verts_sent = 0;
    settings_used = 1;

    ident_verts = '{mk(0, 0, 0, 0),
                    mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                    mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                    mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                    mk(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000),
                    mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hEDCB_A988),
                    mk(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA),
                    mk(32'h7FFF_0000, 32'h8001_0000, 32'h0000_0001, 32'h0000_0000)};
    limit_verts = '{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                    mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                    mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
                    mk(32'h0000_0001, 0, 0, 0)};
    // Half-unit coefficients: products with a fraction, negative ones floor downward.
    round_verts = '{mk(32'hFFFF_FFFF, 0, 0, 0),
                    mk(32'h0000_0001, 0, 0, 0),
                    mk(32'hFFFF_FFFD, 0, 0, 0),
                    mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000)};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: identity after reset, then saturating and rounding matrices.
    foreach (ident_verts[i]) send_vertex(ident_verts[i]);
    wait_drained();
    set_matrix({NUM_REGS{64'h8000_0000_8000_0000}});
    foreach (limit_verts[i]) send_vertex(limit_verts[i]);
    wait_drained();
    set_matrix({NUM_REGS{64'h7FFF_FFFF_7FFF_FFFF}});
    foreach (limit_verts[i]) send_vertex(limit_verts[i]);
    wait_drained();
    set_matrix({NUM_REGS{64'hFFFF_8000_0000_8000}});
    foreach (round_verts[i]) send_vertex(round_verts[i]);

    // Random phases, each under a fresh matrix.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == PHASES - 1) bursts_on = 1'b0;
      set_matrix(rand_matrix());
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) wait_drained();
        send_vertex(mk(rand_word(), rand_word(), rand_word(), rand_word()));
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d vertices under %0d matrix settings; %0d results checked.",
             verts_sent, settings_used, results_checked);
    $display("%0d components clamped; one %0d-cycle output hold-off with input backed up.",
             clamped, LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== vertex_matrix_transform.f =====
hdl/vmt_pkg.sv
hdl/vmt_vert_if.sv
hdl/vmt_res_if.sv
hdl/vmt_regs.sv
hdl/vmt_lane.sv
hdl/vmt_merge.sv
hdl/vertex_matrix_transform.sv
sim/vmt_checker.sv
sim/testbench.sv
